// File: rtl/itp_pkg.sv
package itp_pkg;

  // Byte position counter width (end_position reports the low 16 bits)
  localparam int POSITION_BITS = 16;
  localparam int END_POS_BITS  = 16;
  localparam int VALUE_BITS    = 64;
  localparam int BASE_BITS     = 6;
  localparam int DIGIT_BITS    = 6;

  // Class queue between front and back; depth must be a power of two
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_BITS = $clog2(CQ_DEPTH);

  // Result queue toward the consumer; depth must be a power of two
  localparam int RQ_DEPTH    = 2;
  localparam int RQ_PTR_BITS = $clog2(RQ_DEPTH);

  // Radix codes
  localparam logic [BASE_BITS-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT     = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC     = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_DEFAULT = 6'd10;

  // Digit value for a byte that is no digit at all; above any radix
  localparam logic [DIGIT_BITS-1:0] NO_DIGIT = 6'd63;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  // Parse phases of the back end
  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_AUTO0,
    PH_HEX0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One classified byte
  typedef struct packed {
    logic                  last;
    logic                  nul;
    logic                  space;
    logic                  sign;
    logic                  minus;
    logic                  x_char;
    logic                  zero_char;
    logic [DIGIT_BITS-1:0] digit;
  } char_class_t;

  // Head of the class queue as the back end sees it
  typedef struct packed {
    logic        valid;
    char_class_t item;
  } cq_head_t;

  // One finished string; the sign is applied on the way out
  typedef struct packed {
    logic [VALUE_BITS-1:0]   magnitude;
    logic                    negative;
    logic [END_POS_BITS-1:0] end_position;
  } result_t;

  // Clamp a radix register value to the largest supported radix
  function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
    return (b > BASE_MAX) ? BASE_MAX : b;
  endfunction

endpackage

// File: rtl/itp_front.sv
module itp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  output itp_pkg::cq_head_t     head,
  input  logic                  take
);

  localparam logic [itp_pkg::CQ_PTR_BITS:0] CQ_FULL_CNT =
    (itp_pkg::CQ_PTR_BITS+1)'(itp_pkg::CQ_DEPTH);

  itp_pkg::char_class_t              mem [itp_pkg::CQ_DEPTH];
  logic [itp_pkg::CQ_PTR_BITS-1:0]   wr_ptr;
  logic [itp_pkg::CQ_PTR_BITS-1:0]   rd_ptr;
  logic [itp_pkg::CQ_PTR_BITS:0]     cnt;
  logic                              do_push;
  logic                              do_pop;
  itp_pkg::char_class_t              cls;

  // Digit value of a byte, NO_DIGIT when it is not alphanumeric
  function automatic logic [itp_pkg::DIGIT_BITS-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= itp_pkg::CH_ZERO && c <= itp_pkg::CH_NINE) begin
      t = c - itp_pkg::CH_ZERO;
    end else if (c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LZ) begin
      t = c - itp_pkg::CH_LA + 8'd10;
    end else if (c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UZ) begin
      t = c - itp_pkg::CH_UA + 8'd10;
    end else begin
      t = {2'b00, itp_pkg::NO_DIGIT};
    end
    return t[itp_pkg::DIGIT_BITS-1:0];
  endfunction

  // Classify the incoming byte
  always_comb begin
    cls.last      = last_char;
    cls.nul       = (char_code == itp_pkg::CH_NUL);
    cls.space     = (char_code == itp_pkg::CH_SPACE) || (char_code == itp_pkg::CH_TAB) ||
                    (char_code == itp_pkg::CH_LF)    || (char_code == itp_pkg::CH_CR);
    cls.sign      = (char_code == itp_pkg::CH_PLUS) || (char_code == itp_pkg::CH_MINUS);
    cls.minus     = (char_code == itp_pkg::CH_MINUS);
    cls.x_char    = (char_code == itp_pkg::CH_LX) || (char_code == itp_pkg::CH_UX);
    cls.zero_char = (char_code == itp_pkg::CH_ZERO);
    cls.digit     = digit_of(char_code);
  end

  assign full    = (cnt == CQ_FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = take && (cnt != '0);

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign head.valid = (cnt != '0);
  assign head.item  = mem[rd_ptr];

  // An accepted request is in front of the back end in the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    do_push |=> head.valid)
    else $error("class queue lost a request");

endmodule

// File: rtl/itp_back.sv
module itp_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 number_base_write,
  input  logic [itp_pkg::BASE_BITS-1:0]        number_base,
  input  itp_pkg::cq_head_t                    head,
  output logic                                 take,
  input  logic                                 rq_full,
  output logic                                 rq_push,
  output itp_pkg::result_t                     rq_data
);

  typedef struct packed {
    logic                          consume;
    logic                          take_try;
    logic                          mac;
    logic                          stp;
    logic [itp_pkg::BASE_BITS-1:0] tb;
    logic [itp_pkg::BASE_BITS-1:0] base_next;
    logic                          neg_next;
  } action_t;

  localparam logic [itp_pkg::POSITION_BITS-1:0] POS_CAP = '1;

  logic [itp_pkg::BASE_BITS-1:0]      base_reg;
  itp_pkg::phase_t                    phase;
  itp_pkg::phase_t                    phase_next;
  logic [itp_pkg::VALUE_BITS-1:0]     acc;
  logic [itp_pkg::VALUE_BITS-1:0]     acc_next;
  logic [itp_pkg::BASE_BITS-1:0]      base;
  logic                               neg;
  logic [itp_pkg::POSITION_BITS-1:0]  pos;
  logic [itp_pkg::POSITION_BITS-1:0]  pos_next;
  logic [itp_pkg::POSITION_BITS-1:0]  stop_pos;
  logic [itp_pkg::POSITION_BITS-1:0]  stop_pos_next;
  logic [itp_pkg::POSITION_BITS-1:0]  stop_final;
  logic [itp_pkg::POSITION_BITS+itp_pkg::END_POS_BITS-1:0] stop_wide;
  logic                               adv;
  action_t                            act;
  itp_pkg::char_class_t               it;

  assign it   = head.item;
  assign adv  = head.valid && (!it.last || !rq_full);
  assign take = adv;

  // Actions for the current byte
  always_comb begin
    act           = '0;
    act.tb        = base;
    act.base_next = base;
    act.neg_next  = neg;
    unique case (phase)
      itp_pkg::PH_SPACE, itp_pkg::PH_PREFIX: begin
        if (phase == itp_pkg::PH_SPACE && it.space) begin
          act.consume = 1'b1;
        end else if (phase == itp_pkg::PH_SPACE && it.sign) begin
          act.consume  = 1'b1;
          act.neg_next = it.minus;
        end else if (base == itp_pkg::BASE_AUTO) begin
          if (it.zero_char) begin
            act.consume = 1'b1;
          end else begin
            act.base_next = itp_pkg::BASE_DEC;
            act.tb        = itp_pkg::BASE_DEC;
            act.take_try  = 1'b1;
          end
        end else if (base == itp_pkg::BASE_HEX && it.zero_char) begin
          act.consume = 1'b1;
        end else begin
          act.take_try = 1'b1;
        end
      end
      itp_pkg::PH_AUTO0: begin
        if (it.x_char) begin
          act.base_next = itp_pkg::BASE_HEX;
          act.consume   = 1'b1;
        end else begin
          act.base_next = itp_pkg::BASE_OCT;
          act.tb        = itp_pkg::BASE_OCT;
          act.take_try  = 1'b1;
        end
      end
      itp_pkg::PH_HEX0: begin
        if (it.x_char) begin
          act.consume = 1'b1;
        end else begin
          act.take_try = 1'b1;
        end
      end
      itp_pkg::PH_DIGITS: begin
        act.take_try = 1'b1;
      end
      default: begin
      end
    endcase
    // Digit accepted or parse stops here
    if (act.take_try) begin
      if (!it.nul && (it.digit < act.tb)) begin
        act.mac     = 1'b1;
        act.consume = 1'b1;
      end else begin
        act.stp = 1'b1;
      end
    end
  end

  // Next parse phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      itp_pkg::PH_SPACE, itp_pkg::PH_PREFIX: begin
        if (act.take_try) begin
          phase_next = act.mac ? itp_pkg::PH_DIGITS : itp_pkg::PH_DONE;
        end else if (phase == itp_pkg::PH_SPACE && it.space) begin
          phase_next = itp_pkg::PH_SPACE;
        end else if (phase == itp_pkg::PH_SPACE && it.sign) begin
          phase_next = itp_pkg::PH_PREFIX;
        end else if (base == itp_pkg::BASE_AUTO) begin
          phase_next = itp_pkg::PH_AUTO0;
        end else begin
          phase_next = itp_pkg::PH_HEX0;
        end
      end
      itp_pkg::PH_AUTO0, itp_pkg::PH_HEX0, itp_pkg::PH_DIGITS: begin
        if (act.take_try) begin
          phase_next = act.mac ? itp_pkg::PH_DIGITS : itp_pkg::PH_DONE;
        end else begin
          phase_next = itp_pkg::PH_DIGITS;
        end
      end
      itp_pkg::PH_DONE: phase_next = itp_pkg::PH_DONE;
      default:          phase_next = itp_pkg::PH_DONE;
    endcase
  end

  // Accumulator and position datapath
  always_comb begin
    acc_next      = act.mac ? (acc * act.tb) + itp_pkg::VALUE_BITS'(it.digit) : acc;
    pos_next      = (act.consume && pos != POS_CAP) ? pos + 1'b1 : pos;
    stop_pos_next = act.stp ? pos : stop_pos;
    stop_final    = (phase_next != itp_pkg::PH_DONE) ? pos_next : stop_pos_next;
    stop_wide     = {{itp_pkg::END_POS_BITS{1'b0}}, stop_final};
  end

  // Result on the last byte of a string
  assign rq_push              = adv && it.last;
  assign rq_data.magnitude    = acc_next;
  assign rq_data.negative     = act.neg_next;
  assign rq_data.end_position = stop_wide[itp_pkg::END_POS_BITS-1:0];

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= itp_pkg::BASE_DEFAULT;
    end else if (number_base_write) begin
      base_reg <= number_base;
    end
  end

  // Parse state; the last byte restarts with the current radix
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= itp_pkg::PH_SPACE;
      acc      <= '0;
      base     <= itp_pkg::clamp_base(itp_pkg::BASE_DEFAULT);
      neg      <= 1'b0;
      pos      <= '0;
      stop_pos <= '0;
    end else if (adv) begin
      if (it.last) begin
        phase    <= itp_pkg::PH_SPACE;
        acc      <= '0;
        base     <= itp_pkg::clamp_base(base_reg);
        neg      <= 1'b0;
        pos      <= '0;
        stop_pos <= '0;
      end else begin
        phase    <= phase_next;
        acc      <= acc_next;
        base     <= act.base_next;
        neg      <= act.neg_next;
        pos      <= pos_next;
        stop_pos <= stop_pos_next;
      end
    end
  end

  // A finished string leaves a clean start behind
  a_restart: assert property (@(posedge clk) disable iff (rst)
    adv && it.last |=> phase == itp_pkg::PH_SPACE && pos == '0 && acc == '0)
    else $error("string state not cleared after last byte");

  // Once stopped, further bytes leave value and position alone
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    adv && !it.last && phase == itp_pkg::PH_DONE
      |=> phase == itp_pkg::PH_DONE && acc == $past(acc) && pos == $past(pos))
    else $error("parse state moved after stop");

endmodule

// File: rtl/itp_result_queue.sv
module itp_result_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  itp_pkg::result_t                       data,
  output logic                                   full,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [itp_pkg::VALUE_BITS-1:0]  parsed_value,
  output logic [itp_pkg::END_POS_BITS-1:0]       end_position
);

  localparam logic [itp_pkg::RQ_PTR_BITS:0] RQ_FULL_CNT =
    (itp_pkg::RQ_PTR_BITS+1)'(itp_pkg::RQ_DEPTH);

  itp_pkg::result_t                  mem [itp_pkg::RQ_DEPTH];
  logic [itp_pkg::RQ_PTR_BITS-1:0]   wr_ptr;
  logic [itp_pkg::RQ_PTR_BITS-1:0]   rd_ptr;
  logic [itp_pkg::RQ_PTR_BITS:0]     cnt;
  logic                              do_pop;
  itp_pkg::result_t                  hd;

  assign full   = (cnt == RQ_FULL_CNT);
  assign empty  = (cnt == '0);
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Apply the sign on the way out
  assign hd           = mem[rd_ptr];
  assign parsed_value = $signed(hd.negative ? (~hd.magnitude + 1'b1) : hd.magnitude);
  assign end_position = hd.end_position;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result queue written while full");

  a_fill_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(push))
    else $error("result appeared without a write");

endmodule

// File: rtl/integer_text_parser_unit.sv
// Streaming text-to-integer converter (strtol style).
// Input channel: one string byte per request on char_code, with last_char
// set on its final byte; a request is taken when push is high and full low.
// Result channel: one result per string, parsed_value (signed, wraps modulo
// 2^64) and end_position (bytes consumed before parsing stopped); the oldest
// result is shown while empty is low and is taken when pop is high.
// Radix register: number_base (0 = automatic, 1..36, above 36 acts as 36),
// written when number_base_write is high. The radix is picked up at reset
// and at the end of each string, so a write takes effect from the string
// that starts after the next end of string. Throughput: one byte per cycle
// unless a last byte waits on a full result queue; the back end does one
// 64x6 multiply-add per byte. A last byte is registered in the class queue,
// then in the result queue. A four-entry class queue and a two-entry result
// queue decouple the sides: when the receiver stalls, bytes of the next
// string keep flowing until the back end holds a last byte with the result
// queue full; full then rises once the class queue fills.
// Reset (rst, synchronous) empties both queues and sets the radix to 10.
module integer_text_parser_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [7:0]                             char_code,
  input  logic                                   last_char,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [itp_pkg::VALUE_BITS-1:0]  parsed_value,
  output logic [itp_pkg::END_POS_BITS-1:0]       end_position,
  input  logic                                   number_base_write,
  input  logic [itp_pkg::BASE_BITS-1:0]          number_base
);

  itp_pkg::cq_head_t head;
  logic              take;
  logic              rq_full;
  logic              rq_push;
  itp_pkg::result_t  rq_data;

  itp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .head      (head),
    .take      (take)
  );

  itp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .number_base_write (number_base_write),
    .number_base       (number_base),
    .head              (head),
    .take              (take),
    .rq_full           (rq_full),
    .rq_push           (rq_push),
    .rq_data           (rq_data)
  );

  itp_result_queue u_rq (
    .clk          (clk),
    .rst          (rst),
    .push         (rq_push),
    .data         (rq_data),
    .full         (rq_full),
    .empty        (empty),
    .pop          (pop),
    .parsed_value (parsed_value),
    .end_position (end_position)
  );

endmodule

// File: tb/testbench.sv
module testbench;
  import itp_pkg::*;

  localparam int NOT_A_DIGIT   = 999;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int SEGMENT_ITEMS = 125;
  localparam int LONG_SPACES   = 40;

  typedef logic [7:0] text_t[$];

  typedef struct {
    logic [VALUE_BITS-1:0]   value;
    logic [END_POS_BITS-1:0] position;
  } parse_result_t;

  logic                         clk;
  logic                         rst;
  logic                         push;
  logic                         full;
  logic [7:0]                   char_code;
  logic                         last_char;
  logic                         empty;
  logic                         pop;
  logic signed [VALUE_BITS-1:0] parsed_value;
  logic [END_POS_BITS-1:0]      end_position;
  logic                         number_base_write;
  logic [BASE_BITS-1:0]         number_base;

  // Parser state as predicted
  logic [BASE_BITS-1:0]     base_setting;
  phase_t                   phase;
  logic [VALUE_BITS-1:0]    acc;
  logic [BASE_BITS-1:0]     radix;
  logic                     neg;
  logic [POSITION_BITS-1:0] consumed;
  logic [POSITION_BITS-1:0] stop_at;

  parse_result_t awaited_results[$];
  int            fault_count = 0;
  int            send_gap_max = 0;
  int            recv_gap_max = 0;

  integer_text_parser_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .char_code         (char_code),
    .last_char         (last_char),
    .empty             (empty),
    .pop               (pop),
    .parsed_value      (parsed_value),
    .end_position      (end_position),
    .number_base_write (number_base_write),
    .number_base       (number_base)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
    return NOT_A_DIGIT;
  endfunction

  // Radix is latched here, so a register write lands one string later
  function automatic void begin_string();
    phase    = PH_SPACE;
    acc      = '0;
    radix    = (base_setting > BASE_MAX) ? BASE_MAX : base_setting;
    neg      = 1'b0;
    consumed = '0;
    stop_at  = '0;
  endfunction

  // Position counter saturates
  function automatic void count_byte();
    if (consumed != '1) consumed++;
  endfunction

  function automatic void halt();
    phase   = PH_DONE;
    stop_at = consumed;
  endfunction

  function automatic void digit_step(logic [7:0] c);
    int d;
    d = digit_value(c);
    if (c == CH_NUL || d >= int'(radix)) begin
      halt();
    end else begin
      acc   = acc * VALUE_BITS'(radix) + VALUE_BITS'(d);
      count_byte();
      phase = PH_DIGITS;
    end
  endfunction

  // First byte after whitespace and sign: radix selection
  function automatic void prefix_step(logic [7:0] c);
    if (radix == BASE_AUTO && c == CH_ZERO) begin
      count_byte();
      phase = PH_AUTO0;
    end else if (radix == BASE_HEX && c == CH_ZERO) begin
      count_byte();
      phase = PH_HEX0;
    end else begin
      if (radix == BASE_AUTO) radix = BASE_DEC;
      digit_step(c);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic last);
    logic          is_x;
    parse_result_t r;
    is_x = (c == CH_LX || c == CH_UX);
    case (phase)
      PH_SPACE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
          count_byte();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg   = (c == CH_MINUS);
          count_byte();
          phase = PH_PREFIX;
        end else begin
          prefix_step(c);
        end
      end
      PH_PREFIX: prefix_step(c);
      PH_AUTO0: begin
        if (is_x) begin
          radix = BASE_HEX;
          count_byte();
          phase = PH_DIGITS;
        end else begin
          radix = BASE_OCT;
          digit_step(c);
        end
      end
      PH_HEX0: begin
        if (is_x) begin
          count_byte();
          phase = PH_DIGITS;
        end else begin
          digit_step(c);
        end
      end
      PH_DIGITS: digit_step(c);
      default: ;
    endcase
    // Last byte closes the string
    if (last) begin
      if (phase != PH_DONE) halt();
      r.value    = neg ? -acc : acc;
      r.position = stop_at[END_POS_BITS-1:0];
      awaited_results.push_back(r);
      begin_string();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Push one byte; push stays high afterwards for a back-to-back request
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    last_char <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    parse_byte(c, last);
  endtask

  task automatic send_bytes(input text_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the radix while idle, then close one string so it takes effect
  task automatic program_base(input logic [BASE_BITS-1:0] value);
    wait_drained();
    number_base_write <= 1'b1;
    number_base       <= value;
    @(posedge clk);
    number_base_write <= 1'b0;
    base_setting = value;
    send_char(8'($urandom_range(255, 0)), 1'b1);
  endtask

  function automatic int pick_gap_limit();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 2;
      default: return 18;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1, 0) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  // Mostly well-formed numbers for the current radix, some noise
  task automatic random_string(output text_t s);
    int eff;
    int n;
    int pick;
    logic [7:0] ws[4];
    ws = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    s = {};
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(6, 1)) s.push_back(8'($urandom_range(255, 0)));
    end else begin
      repeat ($urandom_range(2, 0)) s.push_back(ws[$urandom_range(3, 0)]);
      pick = $urandom_range(3, 0);
      if (pick == 0) s.push_back(CH_PLUS);
      else if (pick == 1) s.push_back(CH_MINUS);
      eff  = radix;
      pick = $urandom_range(3, 0);
      if (pick == 0 && (radix == BASE_AUTO || radix == BASE_HEX)) begin
        s.push_back(CH_ZERO);
        s.push_back($urandom_range(1, 0) ? CH_LX : CH_UX);
        eff = 16;
      end else if (pick == 1) begin
        s.push_back(CH_ZERO);
        if (radix == BASE_AUTO) eff = 8;
      end
      if (eff == 0) eff = 10;
      n = ($urandom_range(3, 0) == 0) ? $urandom_range(24, 0) : $urandom_range(6, 0);
      repeat (n) begin
        if ($urandom_range(15, 0) == 0) s.push_back(8'($urandom_range(255, 0)));
        else s.push_back(digit_char($urandom_range(eff - 1, 0)));
      end
      // Terminator and trailing bytes that are ignored
      pick = $urandom_range(3, 0);
      if (pick == 0) s.push_back(CH_NUL);
      else if (pick == 1) s.push_back(8'($urandom_range(255, 0)));
      repeat ($urandom_range(2, 0)) s.push_back(8'($urandom_range(255, 0)));
      if (s.size() == 0) s.push_back(8'($urandom_range(255, 0)));
    end
  endtask

  // ---------------------------------------------------------------- checker

  function automatic void note_mismatch(string field, longint want, longint got);
    fault_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endfunction

  initial begin : result_checker
    parse_result_t want;
    int            gap;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(recv_gap_max, 0);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (awaited_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none actual value %0d position %0d",
                 $time, parsed_value, end_position);
      end else begin
        want = awaited_results.pop_front();
        if (parsed_value !== want.value)
          note_mismatch("parsed_value", longint'(want.value), longint'(parsed_value));
        if (end_position !== want.position)
          note_mismatch("end_position", longint'(want.position), longint'(end_position));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset radix: whitespace, signs, zero byte, top byte value
  task automatic test_default_base();
    text_t s;
    send_gap_max = 18;
    recv_gap_max = 18;
    send_text("\t\n\r -8");
    send_text("+ 5");
    s = {CH_ZERO + 8'd3, CH_NUL, CH_ZERO + 8'd4};
    send_bytes(s);
    s = {8'hff};
    send_bytes(s);
  endtask

  // Automatic radix: hex prefix, lone zero, prefix with no digits
  task automatic test_auto_base();
    send_gap_max = 0;
    recv_gap_max = 18;
    program_base(BASE_AUTO);
    send_text("0x1f");
    send_text("08");
    send_text("-0X");
  endtask

  // Configured hex: zero as digit, skipped prefix
  task automatic test_hex_base();
    send_gap_max = 18;
    recv_gap_max = 0;
    program_base(BASE_HEX);
    send_text("0g");
    send_text("0xF");
  endtask

  task automatic test_unit_base();
    program_base(6'd1);
    send_text("01");
  endtask

  // Register value above 36 acts as 36
  task automatic test_wide_base();
    program_base({BASE_BITS{1'b1}});
    send_text("zZ");
  endtask

  // Long run of whitespace ahead of the digit, bytes back to back
  task automatic test_long_whitespace();
    send_gap_max = 0;
    recv_gap_max = 0;
    program_base(BASE_DEC);
    for (int i = 0; i < LONG_SPACES; i++) send_char(CH_SPACE, 1'b0);
    send_char(CH_ZERO + 8'd5, 1'b1);
  endtask

  task automatic test_random_strings();
    text_t s;
    int    sent;
    int    seg_end;
    logic [BASE_BITS-1:0] b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(7, 0))
        0: b = BASE_AUTO;
        1: b = BASE_HEX;
        2: b = BASE_DEC;
        3: b = BASE_OCT;
        4: b = BASE_MAX;
        5: b = {BASE_BITS{1'b1}};
        6: b = 6'd1;
        default: b = BASE_BITS'($urandom_range(63, 0));
      endcase
      send_gap_max = pick_gap_limit();
      recv_gap_max = pick_gap_limit();
      program_base(b);
      seg_end = sent + SEGMENT_ITEMS;
      while (sent < seg_end) begin
        random_string(s);
        send_bytes(s);
        sent += s.size();
      end
    end
  endtask

  initial begin
    push              <= 1'b0;
    char_code         <= '0;
    last_char         <= 1'b0;
    number_base_write <= 1'b0;
    number_base       <= BASE_DEFAULT;
    rst               <= 1'b1;
    base_setting = BASE_DEFAULT;
    begin_string();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_base();
    test_auto_base();
    test_hex_base();
    test_unit_base();
    test_wide_base();
    test_long_whitespace();
    test_random_strings();

    wait_drained();
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
